/* hdl/hsg_pkg.sv */
// ----------------------------------------------------------------------------
// hsg_pkg
// Shared constants, codes and types of the hop sequence generator.
// ----------------------------------------------------------------------------
package hsg_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CHANNELS = 80;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W        = $clog2(TABLE_DEPTH + 1);
    localparam int CH_W         = 7;
    localparam int SEED_W       = 32;
    localparam int RND_W        = 15;
    localparam int RND_CNT_W    = $clog2(RND_W);

    localparam logic [SEED_W-1:0] LCG_MUL  = 32'd214013;
    localparam logic [SEED_W-1:0] LCG_ADD  = 32'd2531011;
    localparam logic [SEED_W-1:0] LCG_MASK = 32'h7fff_ffff;

    localparam logic [1:0] CFG_SEED  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;

    localparam logic REQ_BUILD  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_LOOK,
        C_FILL,
        C_SHUF,
        C_RWAIT,
        C_RD,
        C_WR_I,
        C_WR_P,
        C_DONE
    } ctrl_state_t;

    typedef enum logic {
        R_IDLE,
        R_DIV
    } rand_state_t;

    typedef struct packed {
        logic              start;
        logic              load;
        logic [SEED_W-1:0] seed;
        logic [CH_W-1:0]   divisor;
    } rand_req_t;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] rem;
    } rand_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  channel;
        logic [LEN_W-1:0] length;
        status_t          status;
    } result_t;

endpackage

/* hdl/hsg_ram.sv */
// ----------------------------------------------------------------------------
// hsg_ram
// Hop table storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hsg_ram
    import hsg_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CH_W-1:0]   wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [CH_W-1:0]   rdata_a,
    output logic [CH_W-1:0]   rdata_b
);

    logic [CH_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hdl/hsg_rand.sv */
// ----------------------------------------------------------------------------
// hsg_rand
// 31-bit LCG step followed by a bit-serial remainder of bits 30..16.
// ----------------------------------------------------------------------------
module hsg_rand
    import hsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rand_req_t req,
    output rand_rsp_t rsp
);

    rand_state_t           state_reg, state_next;
    logic [SEED_W-1:0]     gen_reg;
    logic [SEED_W-1:0]     gen_step;
    logic [RND_W-1:0]      quo_reg;
    logic [CH_W-1:0]       rem_reg;
    logic [RND_CNT_W-1:0]  cnt_reg;
    logic [CH_W:0]         rem_shift;
    logic [CH_W-1:0]       rem_next;
    logic                  last_step;

    assign gen_step  = (SEED_W'(gen_reg * LCG_MUL) + LCG_ADD) & LCG_MASK;
    assign rem_shift = {rem_reg, quo_reg[RND_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, req.divisor})
                     ? CH_W'(rem_shift - {1'b0, req.divisor})
                     : rem_shift[CH_W-1:0];
    assign last_step = (cnt_reg == RND_CNT_W'(RND_W - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                if (last_step)
                begin
                    state_next = R_IDLE;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == R_DIV) && last_step;
        rsp.rem  = rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            gen_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req.load)
            begin
                gen_reg <= req.seed;
            end
            else if (state_reg == R_IDLE && req.start)
            begin
                gen_reg <= gen_step;
                cnt_reg <= '0;
            end
            else if (state_reg == R_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == R_IDLE && req.start)
        begin
            quo_reg <= gen_step[RND_W+15:16];
            rem_reg <= '0;
        end
        else if (state_reg == R_DIV)
        begin
            quo_reg <= {quo_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

/* hdl/hsg_ctrl.sv */
// ----------------------------------------------------------------------------
// hsg_ctrl
// Request sequencer: lookups, table fill and in-place block shuffle.
// ----------------------------------------------------------------------------
module hsg_ctrl
    import hsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [ADDR_W-1:0] hop_index,
    input  logic [SEED_W-1:0] seed_value,
    input  logic [CH_W-1:0]   channel_count,
    input  logic              out_free,
    output result_t           res,
    output rand_req_t         rnd_req,
    input  rand_rsp_t         rnd_rsp,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [CH_W-1:0]   ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr_a,
    output logic [ADDR_W-1:0] ram_raddr_b,
    input  logic [CH_W-1:0]   ram_rdata_a,
    input  logic [CH_W-1:0]   ram_rdata_b
);

    ctrl_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  base_reg;
    logic [CH_W-1:0]   pos_reg;
    logic [CH_W-1:0]   n_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              built_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] part_reg;
    logic [CH_W-1:0]   hold_reg;

    logic              accept;
    logic              count_ok;
    logic [CH_W-1:0]   sync_ch;
    logic [LEN_W-1:0]  cur_addr;
    logic [LEN_W-1:0]  base_plus_n;
    logic [LEN_W-1:0]  base_plus_2n;
    logic              pos_last;
    logic [LEN_W-1:0]  part_calc;
    logic [CH_W-1:0]   fill_val;
    logic              shuf_end;

    assign accept       = in_valid && !in_stall;
    assign count_ok     = (channel_count >= CH_W'(2)) && (channel_count <= CH_W'(MAX_CHANNELS));
    assign sync_ch      = n_reg >> 1;
    assign cur_addr     = base_reg + LEN_W'(pos_reg);
    assign base_plus_n  = base_reg + LEN_W'(n_reg);
    assign base_plus_2n = base_plus_n + LEN_W'(n_reg);
    assign pos_last     = (pos_reg == n_reg - 1'b1);
    assign part_calc    = base_reg + LEN_W'(1) + LEN_W'(rnd_rsp.rem);
    assign shuf_end     = pos_last && (base_plus_n == len_reg);
    assign fill_val     = (pos_reg == '0) ? sync_ch : ((pos_reg == sync_ch) ? '0 : pos_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_LOOKUP)
                        state_next = C_LOOK;
                    else if (count_ok)
                        state_next = C_FILL;
                    else
                        state_next = C_DONE;
                end
            end
            C_LOOK, C_DONE:
            begin
                if (out_free)
                    state_next = C_IDLE;
            end
            C_FILL:
            begin
                if (pos_last && (base_plus_2n > LEN_W'(TABLE_DEPTH)))
                    state_next = C_SHUF;
            end
            C_SHUF:
            begin
                if (pos_reg != '0)
                    state_next = C_RWAIT;
            end
            C_RWAIT:
            begin
                if (rnd_rsp.done)
                    state_next = C_RD;
            end
            C_RD:
            begin
                state_next = C_WR_I;
            end
            C_WR_I:
            begin
                state_next = C_WR_P;
            end
            C_WR_P:
            begin
                state_next = shuf_end ? C_DONE : C_SHUF;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall        = (state_reg != C_IDLE);
        rnd_req.start   = (state_reg == C_SHUF) && (pos_reg != '0);
        rnd_req.load    = accept && (req_type == REQ_BUILD) && count_ok;
        rnd_req.seed    = seed_value;
        rnd_req.divisor = n_reg - 1'b1;
        ram_we          = 1'b0;
        ram_waddr       = cur_addr[ADDR_W-1:0];
        ram_wdata       = fill_val;
        ram_re          = 1'b0;
        ram_raddr_a     = hop_index;
        ram_raddr_b     = part_reg;
        res.valid       = 1'b0;
        res.channel     = '0;
        res.length      = len_reg;
        res.status      = built_reg ? ST_OK : ST_NOT_BUILT;
        unique case (state_reg)
            C_IDLE:
            begin
                ram_re = accept && (req_type == REQ_LOOKUP);
            end
            C_LOOK:
            begin
                res.valid = out_free;
                if (!built_reg)
                    res.status = ST_NOT_BUILT;
                else if ({1'b0, idx_reg} >= len_reg)
                    res.status = ST_RANGE;
                else
                    res.channel = ram_rdata_a;
            end
            C_DONE:
            begin
                res.valid = out_free;
            end
            C_FILL:
            begin
                ram_we = 1'b1;
            end
            C_RD:
            begin
                ram_re      = 1'b1;
                ram_raddr_a = cur_addr[ADDR_W-1:0];
            end
            C_WR_I:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata_b;
            end
            C_WR_P:
            begin
                ram_we    = 1'b1;
                ram_waddr = part_reg;
                ram_wdata = hold_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            base_reg  <= '0;
            pos_reg   <= '0;
            n_reg     <= CH_W'(2);
            len_reg   <= '0;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (accept && req_type == REQ_BUILD)
                    begin
                        base_reg  <= '0;
                        pos_reg   <= '0;
                        built_reg <= 1'b0;
                        len_reg   <= '0;
                        if (count_ok)
                            n_reg <= channel_count;
                    end
                end
                C_FILL:
                begin
                    if (pos_last)
                    begin
                        pos_reg <= '0;
                        if (base_plus_2n > LEN_W'(TABLE_DEPTH))
                        begin
                            len_reg  <= base_plus_n;
                            base_reg <= '0;
                        end
                        else
                        begin
                            base_reg <= base_plus_n;
                        end
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                C_SHUF:
                begin
                    if (pos_reg == '0)
                        pos_reg <= pos_reg + 1'b1;
                end
                C_WR_P:
                begin
                    if (pos_last)
                    begin
                        pos_reg  <= '0;
                        base_reg <= base_plus_n;
                        if (shuf_end)
                            built_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            idx_reg <= hop_index;
        if (state_reg == C_RWAIT && rnd_rsp.done)
        begin
            if (part_calc >= LEN_W'(TABLE_DEPTH))
                part_reg <= ADDR_W'(TABLE_DEPTH - 1);
            else
                part_reg <= part_calc[ADDR_W-1:0];
        end
        if (state_reg == C_WR_I)
            hold_reg <= ram_rdata_a;
    end

endmodule

/* hdl/hop_sequence_generator_top.sv */
// ----------------------------------------------------------------------------
// hop_sequence_generator_top
// Channel hop table builder and lookup.
//
// Input channel (in_valid/in_stall) carries req_type and hop_index; every
// transfer yields exactly one result transfer on the output channel
// (out_valid/out_stall) with channel, sequence_length and status.
// Configuration writes (cfg_valid/cfg_ready, always ready) set seed_value
// (index 0) and channel_count (index 1); other indexes are ignored. They
// only take effect at the next rebuild.
// Lookup: the table read starts at the input transfer; the read data and
// then the result are registered, and no new request is taken until the
// result has entered the result register.
// Rebuild: a fill pass over the table, a start step per block, then per
// non-first entry an LCG step, a 15-bit bit-serial remainder, a read and
// two write-backs, then the result.
// Reset clears control state; no table is built. While the output stalls
// the result register holds and no new input is taken once the next
// result is ready.
// ----------------------------------------------------------------------------
module hop_sequence_generator_top
    import hsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [ADDR_W-1:0] hop_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CH_W-1:0]   channel,
    output logic [LEN_W-1:0]  sequence_length,
    output logic [1:0]        status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [SEED_W-1:0] cfg_data
);

    logic [SEED_W-1:0] seed_reg;
    logic [CH_W-1:0]   count_reg;
    logic              out_valid_reg;
    logic [CH_W-1:0]   channel_reg;
    logic [LEN_W-1:0]  length_reg;
    status_t           status_reg;
    logic              out_free;

    result_t           res;
    rand_req_t         rnd_req;
    rand_rsp_t         rnd_rsp;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [CH_W-1:0]   ram_wdata;
    logic [CH_W-1:0]   ram_rdata_a;
    logic [CH_W-1:0]   ram_rdata_b;

    assign cfg_ready       = 1'b1;
    assign out_free        = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign channel         = channel_reg;
    assign sequence_length = length_reg;
    assign status          = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            count_reg <= CH_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEED:  seed_reg  <= cfg_data;
                CFG_COUNT: count_reg <= cfg_data[CH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            channel_reg <= res.channel;
            length_reg  <= res.length;
            status_reg  <= res.status;
        end
    end

    hsg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .hop_index     (hop_index),
        .seed_value    (seed_reg),
        .channel_count (count_reg),
        .out_free      (out_free),
        .res           (res),
        .rnd_req       (rnd_req),
        .rnd_rsp       (rnd_rsp),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr_a   (ram_raddr_a),
        .ram_raddr_b   (ram_raddr_b),
        .ram_rdata_a   (ram_rdata_a),
        .ram_rdata_b   (ram_rdata_b)
    );

    hsg_rand u_rand (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rnd_req),
        .rsp   (rnd_rsp)
    );

    hsg_ram u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

endmodule

/* hdl/hsg_checker.sv */
// ----------------------------------------------------------------------------
// hsg_checker
// Port-level checks of the hop sequence generator results.
// ----------------------------------------------------------------------------
module hsg_checker
    import hsg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CH_W-1:0]   channel,
    input logic [LEN_W-1:0]  sequence_length,
    input logic [1:0]        status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel)
            && $stable(sequence_length) && $stable(status))
        else $error("stalled result changed");

    a_not_built: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NOT_BUILT |-> channel == '0 && sequence_length == '0)
        else $error("no-table result carries data");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> channel == '0 && sequence_length != '0)
        else $error("out-of-range result malformed");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> sequence_length != '0
            && sequence_length <= LEN_W'(TABLE_DEPTH)
            && channel < CH_W'(MAX_CHANNELS))
        else $error("ok result out of bounds");

endmodule

bind hop_sequence_generator_top hsg_checker u_hsg_checker (.*);

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hop_sequence_generator_top.
//
// Rebuild and lookup requests are queued by a phase sequencer and sent by a
// clocked driver. Each accepted transfer is run through a local model of the
// table build (block fill, sync swap, LCG shuffle) and lookup. A clocked
// monitor compares every result transfer, field by field, against the
// oldest predicted answer. Configuration is rewritten between phases. Both
// channels idle at random, and one phase holds the result channel off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
    import hsg_pkg::*;

    localparam int          HALF_PERIOD    = 10;
    localparam int          RESET_CYCLES   = 9;
    localparam int          RANDOM_ITEMS   = 950;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT = 30000;
    localparam int          MAX_PRINTED    = 40;
    localparam int          PRESSURE_PHASE = 2;
    localparam logic [1:0]  CFG_SPARE_A    = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B    = 2'd3;

    typedef struct {
        logic              req;
        logic [ADDR_W-1:0] idx;
    } hop_req_t;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [LEN_W-1:0] length;
        status_t          status;
    } hop_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              req_type  = REQ_LOOKUP;
    logic [ADDR_W-1:0] hop_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CH_W-1:0]   channel;
    logic [LEN_W-1:0]  sequence_length;
    logic [1:0]        status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [SEED_W-1:0] cfg_data  = '0;

    // local copy of the block's registers and table
    logic [SEED_W-1:0] seed_reg  = '0;
    logic [CH_W-1:0]   count_reg = CH_W'(2);
    logic [CH_W-1:0]   chan_map [TABLE_DEPTH];
    logic [LEN_W-1:0]  map_len   = '0;
    logic              map_valid = 1'b0;

    hop_req_t    pending_reqs [$];
    hop_result_t hop_answers_q [$];

    bit hold_off      = 1'b0;
    bit pressure_req  = 1'b0;
    bit send_idle_en  = 1'b0;
    bit recv_idle_en  = 1'b0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int builds_ok     = 0;
    int builds_bad    = 0;
    int lookups_ok    = 0;
    int lookups_range = 0;
    int lookups_cold  = 0;

    hop_sequence_generator_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .hop_index       (hop_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .channel         (channel),
        .sequence_length (sequence_length),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int pick_gap(bit en);
        int r;
        if (!en || $urandom_range(0, 2) != 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // table build and lookup, applied at each accepted request
    function automatic hop_result_t predict_hop(logic req, logic [ADDR_W-1:0] idx);
        int               n;
        int               len;
        int               sync_ch;
        int               c;
        int               p;
        logic [SEED_W-1:0] g;
        logic [CH_W-1:0]   t;
        hop_result_t      r;
        r.channel = '0;
        r.length  = '0;
        r.status  = ST_OK;
        if (req == REQ_BUILD) begin
            n = int'(count_reg);
            if (n < 2 || n > MAX_CHANNELS) begin
                map_valid = 1'b0;
                map_len   = '0;
                r.status  = ST_NOT_BUILT;
            end
            else begin
                len     = (TABLE_DEPTH / n) * n;
                sync_ch = n / 2;
                for (int i = 0; i < len; i++) begin
                    c = i % n;
                    chan_map[i] = CH_W'((c == 0) ? sync_ch : ((c == sync_ch) ? 0 : c));
                end
                g = seed_reg;
                for (int i = 0; i < len; i++) begin
                    if (i % n != 0) begin
                        g = (g * LCG_MUL + LCG_ADD) & LCG_MASK;
                        p = (i / n) * n + 1 + (int'(g[30:16]) % (n - 1));
                        if (p >= TABLE_DEPTH)
                            p = TABLE_DEPTH - 1;
                        t           = chan_map[i];
                        chan_map[i] = chan_map[p];
                        chan_map[p] = t;
                    end
                end
                map_len   = LEN_W'(len);
                map_valid = 1'b1;
                r.length  = map_len;
            end
        end
        else if (!map_valid) begin
            r.status = ST_NOT_BUILT;
        end
        else begin
            r.length = map_len;
            if ({1'b0, idx} >= map_len)
                r.status = ST_RANGE;
            else
                r.channel = chan_map[idx];
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        hop_req_t    nxt;
        hop_result_t res;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                res = predict_hop(req_type, hop_index);
                hop_answers_q.insert(hop_answers_q.size(), res);
                if (req_type == REQ_BUILD) begin
                    if (res.status == ST_OK)
                        builds_ok++;
                    else
                        builds_bad++;
                end
                else if (res.status == ST_OK)
                    lookups_ok++;
                else if (res.status == ST_RANGE)
                    lookups_range++;
                else
                    lookups_cold++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= nxt.req;
                    hop_index <= nxt.idx;
                    send_gap  <= pick_gap(send_idle_en);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        hop_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (hop_answers_q.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end
                else begin
                    want = hop_answers_q.pop_front();
                    if (channel !== want.channel)
                        report_mismatch($sformatf("result %0d: channel %0d, predicted %0d",
                                                  results_seen, channel, want.channel));
                    if (sequence_length !== want.length)
                        report_mismatch($sformatf("result %0d: length %0d, predicted %0d",
                                                  results_seen, sequence_length, want.length));
                    if (status !== want.status)
                        report_mismatch($sformatf("result %0d: status %0d, predicted %s",
                                                  results_seen, status, want.status.name()));
                end
            end
            out_stall <= hold_off || (recv_gap != 0);
            if (recv_gap != 0)
                recv_gap <= recv_gap - 1;
            else
                recv_gap <= pick_gap(recv_idle_en);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (pressure_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic cfg_write(logic [1:0] idx, logic [SEED_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SEED:  seed_reg  = data;
            CFG_COUNT: count_reg = data[CH_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic queue_req(logic req, logic [ADDR_W-1:0] idx);
        hop_req_t item;
        item.req = req;
        item.idx = idx;
        pending_reqs.insert(pending_reqs.size(), item);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || hop_answers_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_index(int bound);
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 9);
        if (r < 6)
            return ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
        if (r < 8) begin
            lo = (bound > 3) ? bound - 3 : 0;
            hi = (bound + 2 < TABLE_DEPTH) ? bound + 2 : TABLE_DEPTH - 1;
            return ADDR_W'($urandom_range(hi, lo));
        end
        return (r == 8) ? '0 : '1;
    endfunction

    // phase sequencer
    initial
    begin
        int sent;
        int n_items;
        int count;
        int bound_len;
        int r;
        sent = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: lookups on an empty table, then smallest count
        queue_req(REQ_LOOKUP, '0);
        queue_req(REQ_LOOKUP, '1);
        queue_req(REQ_BUILD, 8'hA5);
        queue_req(REQ_LOOKUP, '0);
        queue_req(REQ_LOOKUP, 8'd1);
        queue_req(REQ_LOOKUP, '1);
        wait_idle();

        // largest count; old table must survive the register writes
        cfg_write(CFG_SEED, '1);
        cfg_write(CFG_COUNT, MAX_CHANNELS);
        @(negedge clk);
        queue_req(REQ_LOOKUP, '1);
        queue_req(REQ_BUILD, '0);
        queue_req(REQ_LOOKUP, '0);
        queue_req(REQ_LOOKUP, 8'd239);
        queue_req(REQ_LOOKUP, 8'd240);
        queue_req(REQ_LOOKUP, '1);
        wait_idle();

        // counts out of range drop the table
        cfg_write(CFG_COUNT, 32'd1);
        @(negedge clk);
        queue_req(REQ_BUILD, '1);
        queue_req(REQ_LOOKUP, '0);
        wait_idle();
        cfg_write(CFG_COUNT, 32'hFFFF_FF80);
        @(negedge clk);
        queue_req(REQ_BUILD, '0);
        wait_idle();
        cfg_write(CFG_COUNT, 32'd127);
        @(negedge clk);
        queue_req(REQ_BUILD, '0);
        wait_idle();
        cfg_write(CFG_COUNT, MAX_CHANNELS + 1);
        @(negedge clk);
        queue_req(REQ_BUILD, '0);
        wait_idle();

        // writes to unused indexes are dropped
        cfg_write(CFG_SPARE_A, '1);
        cfg_write(CFG_SPARE_B, 32'h5A5A_A5A5);
        cfg_write(CFG_COUNT, 32'd3);
        cfg_write(CFG_SEED, 32'h8000_0000);
        @(negedge clk);
        queue_req(REQ_BUILD, '0);
        queue_req(REQ_LOOKUP, 8'd254);
        queue_req(REQ_LOOKUP, '1);
        queue_req(REQ_LOOKUP, 8'd128);
        wait_idle();

        // random phases: rebuild then lookups, with some noise
        for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
            if (ph % 4 == 0)
                cfg_write(CFG_SEED, ($urandom_range(0, 1) != 0) ? '1 : '0);
            else
                cfg_write(CFG_SEED, $urandom());
            r = $urandom_range(0, 9);
            if (r == 0)
                count = $urandom_range(0, 1);
            else if (r == 1)
                count = $urandom_range(MAX_CHANNELS + 1, 127);
            else if (r == 2)
                count = 2;
            else if (r == 3)
                count = MAX_CHANNELS;
            else
                count = $urandom_range(2, MAX_CHANNELS);
            cfg_write(CFG_COUNT, ($urandom() & 32'hFFFF_FF80) | SEED_W'(count));
            if ($urandom_range(0, 7) == 0)
                cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
            bound_len = (count >= 2 && count <= MAX_CHANNELS) ? (TABLE_DEPTH / count) * count : 0;
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            @(negedge clk);

            if (ph == PRESSURE_PHASE) begin
                send_idle_en = 1'b0;
                pressure_req = 1'b1;
                for (int k = 0; k < 60; k++)
                    queue_req(REQ_LOOKUP, pick_index(int'(map_len)));
                sent += 60;
            end
            else begin
                if ($urandom_range(0, 4) == 0) begin
                    n_items = $urandom_range(1, 3);
                    for (int k = 0; k < n_items; k++)
                        queue_req(REQ_LOOKUP, pick_index(int'(map_len)));
                    sent += n_items;
                end
                queue_req(REQ_BUILD, ADDR_W'($urandom()));
                n_items = $urandom_range(20, 40);
                for (int k = 0; k < n_items; k++) begin
                    if ($urandom_range(0, 49) == 0)
                        queue_req(REQ_BUILD, ADDR_W'($urandom()));
                    else
                        queue_req(REQ_LOOKUP, pick_index(bound_len));
                end
                sent += n_items + 1;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d rebuilds (%0d rejected counts) and %0d config writes",
                 builds_ok + builds_bad, builds_bad, cfg_writes);
        $display("lookups: %0d hits, %0d out of range, %0d with no table; %0d results checked",
                 lookups_ok, lookups_range, lookups_cold, results_seen);
        if (error_count == 0 && hop_answers_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
